// ===== design/nwbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the neuron weight update block.
// No dependencies; imported by nwbm_front, nwbm_back and the top level.
package nwbm_pkg;

    localparam int DEF_MAX_WEIGHTS = 64;
    localparam int IDX_W           = 6;
    localparam int VAL_W           = 32;
    localparam int SUM_W           = 48;
    localparam int RATE_W          = 16;
    localparam int DATA_W          = 40;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [RATE_W-1:0] DEF_RATE     = 16'd9830;
    localparam logic [RATE_W-1:0] DEF_MOMENTUM = 16'd32768;

    // Register select is byte address bit 2.
    localparam logic REG_RATE     = 1'b0;
    localparam logic REG_MOMENTUM = 1'b1;

    // Input opcodes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SETACT = 2'd1;
    localparam logic [1:0] OP_ACC    = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // Result kinds.
    localparam logic KIND_SUM    = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    // Command queue between front and back; depth is a power of two.
    localparam int QD    = 2;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    typedef enum logic [2:0] {
        K_NOP  = 3'd0,
        K_LOAD = 3'd1,
        K_ACT  = 3'd2,
        K_ACC  = 3'd3,
        K_UPD  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] operand;
        logic                    last;
        logic                    ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic pop;
        logic init_done;
    } t_bk_stat;

endpackage

// ===== design/neuron_weight_backprop_momentum.sv =====
`timescale 1ns / 1ps
// Top level of the neuron weight update block: configuration registers,
// front end and back end. Depends on nwbm_pkg, nwbm_front and nwbm_back.

// One neuron's outgoing weights trained by SGD with momentum in signed Q8.24.
// After reset the block sweeps the change memory to zero and accepts no
// transaction until that is done. Commands pass from the input side through a
// two-entry queue to a sequencer with a single shared 33x33 multiplier: load
// weight and set activation finish in the idle state, accumulate runs through
// states A1 and A2, and update through U1 to U5, since its three dependent
// multiplications and two saturating sums go through that one multiplier and
// then the change and weight memories in turn. A finished result waits in an
// output register while further transactions are queued. Indexes at or above
// MAX_WEIGHTS are ignored by load and update and add zero in accumulate.
module neuron_weight_backprop_momentum import nwbm_pkg::*; #(
    parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [5:0] weight_index, [37:6] operand, rest zero
    input  logic [1:0]        i_s_tuser,   // [1:0] opcode
    input  logic              i_s_tlast,   // last_in_run
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // [5:0] result_index, [37:6] result_value
    output logic              o_m_tuser,   // result_kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [RATE_W-1:0] r_rate;
    logic [RATE_W-1:0] r_momentum;
    logic              cfg_wr;
    t_bk_stat          stat;
    t_q_head           head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= DEF_RATE;
            r_momentum <= DEF_MOMENTUM;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_RATE:     r_rate     <= pwdata[RATE_W-1:0];
                REG_MOMENTUM: r_momentum <= pwdata[RATE_W-1:0];
                default:      r_rate     <= r_rate;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RATE:     prdata = {{(APB_DW-RATE_W){1'b0}}, r_rate};
            REG_MOMENTUM: prdata = {{(APB_DW-RATE_W){1'b0}}, r_momentum};
            default:      prdata = '0;
        endcase
    end

    nwbm_front #(
        .MAX_WEIGHTS (MAX_WEIGHTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_stat     (stat),
        .o_head     (head)
    );

    nwbm_back #(
        .MAX_WEIGHTS (MAX_WEIGHTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rate     (r_rate),
        .i_momentum (r_momentum),
        .i_head     (head),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== design/nwbm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them into commands
// and holds them in a short queue for the back end. Depends on nwbm_pkg.
module nwbm_front import nwbm_pkg::*; #(
    parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [5:0] weight_index, [37:6] operand
    input  logic [1:0]        i_s_tuser,   // [1:0] opcode
    input  logic              i_s_tlast,   // last_in_run
    input  t_bk_stat          i_stat,
    output t_q_head           o_head
);

    t_cmd             r_q [QD];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    t_cmd n_cmd;
    logic full;
    logic push;
    logic pop;

    assign full       = (r_cnt == CNT_W'(QD));
    assign o_s_tready = !full && i_stat.init_done;
    assign pop        = i_stat.pop;

    always_comb begin
        n_cmd.idx     = i_s_tdata[IDX_W-1:0];
        n_cmd.operand = $signed(i_s_tdata[IDX_W +: VAL_W]);
        n_cmd.last    = i_s_tlast;
        n_cmd.ok      = (32'(i_s_tdata[IDX_W-1:0]) < MAX_WEIGHTS);
        case (i_s_tuser)
            OP_LOAD:   n_cmd.kind = n_cmd.ok ? K_LOAD : K_NOP;
            OP_SETACT: n_cmd.kind = K_ACT;
            OP_ACC:    n_cmd.kind = K_ACC;
            OP_UPDATE: n_cmd.kind = n_cmd.ok ? K_UPD : K_NOP;
            default:   n_cmd.kind = K_NOP;
        endcase
    end

    // Transactions that have no effect at all are dropped here.
    assign push = i_s_tvalid && o_s_tready && (n_cmd.kind != K_NOP);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

// ===== design/nwbm_back.sv =====
`timescale 1ns / 1ps
// Back end: weight and change memories, the shared multiplier, the
// accumulate/update sequencer and the output register. Depends on nwbm_pkg.
module nwbm_back import nwbm_pkg::*; #(
    parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [RATE_W-1:0] i_rate,
    input  logic [RATE_W-1:0] i_momentum,
    input  t_q_head           i_head,
    output t_bk_stat          o_stat,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,   // [5:0] result_index, [37:6] result_value
    output logic              o_m_tuser    // result_kind
);

    localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int PW = 2 * (VAL_W + 1);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_A1    = 9'b000000100,
        ST_A2    = 9'b000001000,
        ST_U1    = 9'b000010000,
        ST_U2    = 9'b000100000,
        ST_U3    = 9'b001000000,
        ST_U4    = 9'b010000000,
        ST_U5    = 9'b100000000
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W:0] v);
        logic fits;
        fits = (&v[SUM_W:VAL_W-1]) || !(|v[SUM_W:VAL_W-1]);
        if (fits) begin
            sat32 = v[VAL_W-1:0];
        end else if (v[SUM_W]) begin
            sat32 = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
        if (v[SUM_W] == v[SUM_W-1]) begin
            sat48 = v[SUM_W-1:0];
        end else if (v[SUM_W]) begin
            sat48 = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sat48 = {1'b0, {(SUM_W-1){1'b1}}};
        end
    endfunction

    logic signed [VAL_W-1:0] wmem [MAX_WEIGHTS];
    logic signed [VAL_W-1:0] cmem [MAX_WEIGHTS];

    t_state                  r_state;
    t_state                  n_state;
    logic [AW-1:0]           r_clr;
    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_act;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_wrd;
    logic signed [VAL_W-1:0] r_crd;
    logic signed [PW-1:0]    r_prod;
    logic signed [PW-25:0]   r_t;
    logic signed [VAL_W-1:0] r_ch;
    logic                    r_out_valid;
    logic                    r_out_kind;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [VAL_W-1:0] r_out_val;

    logic                    pop;
    logic                    slot_free;
    logic [AW-1:0]           head_addr;
    logic [AW-1:0]           cmd_addr;
    logic signed [VAL_W:0]   mul_a;
    logic signed [VAL_W:0]   mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [PW-25:0]   acc_p;
    logic signed [SUM_W-1:0] acc_new;
    logic signed [VAL_W-1:0] upd_ch;
    logic signed [VAL_W-1:0] upd_w;
    logic                    acc_go;

    assign slot_free = !r_out_valid || i_m_tready;
    assign pop       = (r_state == ST_IDLE) && i_head.valid;
    assign head_addr = AW'(i_head.cmd.idx);
    assign cmd_addr  = AW'(r_cmd.idx);

    assign o_stat.pop       = pop;
    assign o_stat.init_done = (r_state != ST_CLEAR);

    // One shared signed multiplier; the product is always registered.
    always_comb begin
        case (r_state)
            ST_A1: begin
                mul_a = {r_wrd[VAL_W-1], r_wrd};
                mul_b = {r_cmd.operand[VAL_W-1], r_cmd.operand};
            end
            ST_U1: begin
                mul_a = {{(VAL_W+1-RATE_W){1'b0}}, i_rate};
                mul_b = {r_act[VAL_W-1], r_act};
            end
            ST_U2: begin
                mul_a = r_prod[VAL_W+16:16];
                mul_b = {r_cmd.operand[VAL_W-1], r_cmd.operand};
            end
            ST_U3: begin
                mul_a = {{(VAL_W+1-RATE_W){1'b0}}, i_momentum};
                mul_b = {r_crd[VAL_W-1], r_crd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Accumulate: drop 24 fraction bits of the product, then saturating add.
    assign acc_p   = r_cmd.ok ? r_prod[PW-1:24] : '0;
    assign acc_new = sat48({{(SUM_W+1-(PW-24)){acc_p[PW-25]}}, acc_p}
                         + {r_sum[SUM_W-1], r_sum});
    assign acc_go  = !r_cmd.last || slot_free;

    assign upd_ch = sat32({{(SUM_W+1-(PW-24)){r_t[PW-25]}}, r_t}
                        + {{(SUM_W-VAL_W){r_prod[VAL_W+16]}}, r_prod[VAL_W+16:16]});
    assign upd_w  = sat32({{(SUM_W+1-VAL_W){r_wrd[VAL_W-1]}}, r_wrd}
                        + {{(SUM_W+1-VAL_W){r_ch[VAL_W-1]}}, r_ch});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(MAX_WEIGHTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    case (i_head.cmd.kind)
                        K_ACC:   n_state = ST_A1;
                        K_UPD:   n_state = ST_U1;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_A1: n_state = ST_A2;
            ST_A2: begin
                if (acc_go) begin
                    n_state = ST_IDLE;
                end
            end
            ST_U1: n_state = ST_U2;
            ST_U2: n_state = ST_U3;
            ST_U3: n_state = ST_U4;
            ST_U4: n_state = ST_U5;
            ST_U5: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Weight memory: written by load and by update, read when a command starts.
    always_ff @(posedge i_clk) begin
        if (pop && (i_head.cmd.kind == K_LOAD)) begin
            wmem[head_addr] <= i_head.cmd.operand;
        end else if ((r_state == ST_U5) && slot_free) begin
            wmem[cmd_addr] <= upd_w;
        end
        if (pop) begin
            r_wrd <= wmem[head_addr];
        end
    end

    // Change memory: cleared by the sweep after reset, written by update.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            cmem[r_clr] <= '0;
        end else if (r_state == ST_U4) begin
            cmem[cmd_addr] <= upd_ch;
        end
        if (pop) begin
            r_crd <= cmem[head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_head.cmd;
        end
        // The accumulate product is held while the sum waits for the output slot.
        if (r_state != ST_A2) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_U3) begin
            r_t <= r_prod[PW-1:24];
        end
        if (r_state == ST_U4) begin
            r_ch <= upd_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_act       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= KIND_SUM;
            r_out_idx   <= '0;
            r_out_val   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (pop && (i_head.cmd.kind == K_ACT)) begin
                r_act <= i_head.cmd.operand;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == ST_A2) && acc_go) begin
                if (r_cmd.last) begin
                    r_sum       <= '0;
                    r_out_valid <= 1'b1;
                    r_out_kind  <= KIND_SUM;
                    r_out_idx   <= '0;
                    r_out_val   <= sat32({acc_new[SUM_W-1], acc_new});
                end else begin
                    r_sum <= acc_new;
                end
            end
            if ((r_state == ST_U5) && slot_free) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= KIND_WEIGHT;
                r_out_idx   <= r_cmd.idx;
                r_out_val   <= upd_w;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{(DATA_W-IDX_W-VAL_W){1'b0}}, r_out_val, r_out_idx};

endmodule

// ===== tb/neuron_weight_backprop_momentum_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of neuron_weight_backprop_momentum: directed table, then random
// training streams, results checked by fixed-point model or table. Depends on nwbm_pkg.
module neuron_weight_backprop_momentum_tb;
    import nwbm_pkg::*;

    localparam int     N_WEIGHTS      = DEF_MAX_WEIGHTS;
    localparam int     PHASE_ITEMS    = 500;
    localparam int     DRAIN_CYCLES   = 30;
    localparam int     STALL_LIMIT    = 5000;
    localparam longint SUM_HI         = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO         = -SUM_HI - 1;
    localparam logic [APB_AW-1:0] RATE_ADDR     = {REG_RATE, 2'b00};
    localparam logic [APB_AW-1:0] MOMENTUM_ADDR = {REG_MOMENTUM, 2'b00};

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] operand;
        logic                    last;
    } t_item;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_result;

    typedef struct {
        t_item   it;
        bit      fixed;
        t_result res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata = '0;   // [5:0] weight_index, [37:6] operand, rest zero
    logic [1:0]        i_s_tuser = OP_LOAD;   // [1:0] opcode
    logic              i_s_tlast = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;   // [5:0] result_index, [37:6] result_value
    logic              o_m_tuser;   // result_kind
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    neuron_weight_backprop_momentum dut (.*);

    always #5 i_clk = ~i_clk;

    // Model state of the neuron.
    logic signed [VAL_W-1:0] weight_mem [N_WEIGHTS];
    logic signed [VAL_W-1:0] change_mem [N_WEIGHTS];
    bit                      weight_loaded [N_WEIGHTS];
    logic signed [VAL_W-1:0] activation_q;
    longint                  grad_sum;
    logic [RATE_W-1:0]       rate_reg;
    logic [RATE_W-1:0]       momentum_reg;

    t_result due_results [$];
    t_row    script [$];
    int      errors = 0;
    int      send_idle_pct = 29;
    int      recv_idle_pct = 53;
    int      quiet_cycles = 0;

    function automatic logic signed [VAL_W-1:0] clip32(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint clip48(input longint v);
        if (v > SUM_HI)
            return SUM_HI;
        if (v < SUM_LO)
            return SUM_LO;
        return v;
    endfunction

    // Applies one accepted item to the model; returns 1 when it yields a result.
    function automatic bit train_step(input t_item it, output t_result res);
        longint                  prod;
        longint                  rate_act;
        longint                  term;
        longint                  mom_term;
        logic signed [VAL_W-1:0] new_change;
        logic signed [VAL_W-1:0] new_weight;
        bit                      in_range;
        in_range = int'(it.idx) < N_WEIGHTS;
        res = '0;
        train_step = 1'b0;
        case (it.op)
            OP_LOAD: begin
                if (in_range) begin
                    weight_mem[it.idx] = it.operand;
                    weight_loaded[it.idx] = 1'b1;
                end
            end
            OP_SETACT: activation_q = it.operand;
            OP_ACC: begin
                if (in_range) begin
                    prod = (longint'($signed(weight_mem[it.idx])) *
                            longint'($signed(it.operand))) >>> 24;
                    grad_sum = clip48(grad_sum + prod);
                end
                if (it.last) begin
                    res.kind = KIND_SUM;
                    res.idx = '0;
                    res.value = clip32(grad_sum);
                    grad_sum = 0;
                    train_step = 1'b1;
                end
            end
            default: begin
                if (in_range) begin
                    rate_act = (longint'(rate_reg) * longint'($signed(activation_q))) >>> 16;
                    term = (rate_act * longint'($signed(it.operand))) >>> 24;
                    mom_term = (longint'(momentum_reg) *
                                longint'($signed(change_mem[it.idx]))) >>> 16;
                    new_change = clip32(term + mom_term);
                    new_weight = clip32(longint'($signed(weight_mem[it.idx])) +
                                        longint'($signed(new_change)));
                    change_mem[it.idx] = new_change;
                    weight_mem[it.idx] = new_weight;
                    res.kind = KIND_WEIGHT;
                    res.idx = it.idx;
                    res.value = new_weight;
                    train_step = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return $urandom();
            // Half the picks are values within two units of zero so that sums stay off the rails.
            default: return $urandom_range(32'h03FF_FFFF) - 32'h0200_0000;
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        pick = $urandom_range(99);
        // A small working set keeps momentum building up on the same weights.
        it.idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(N_WEIGHTS - 1))
                                          : IDX_W'($urandom_range(7));
        it.operand = pick_operand();
        it.last = 1'($urandom_range(1));
        if (pick < 15)
            it.op = OP_LOAD;
        else if (pick < 25)
            it.op = OP_SETACT;
        else if (pick < 65) begin
            it.op = OP_ACC;
            it.last = ($urandom_range(3) == 0);
        end else
            it.op = OP_UPDATE;
        // Never read a weight that was never loaded.
        if ((it.op == OP_ACC || it.op == OP_UPDATE) && !weight_loaded[it.idx])
            it.op = OP_LOAD;
        return it;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] operand, input logic last,
                           input bit fixed, input logic kind, input logic [VAL_W-1:0] value);
        t_row r;
        r.it = '{op: op, idx: idx, operand: operand, last: last};
        r.fixed = fixed;
        r.res = '{kind: kind, idx: (kind == KIND_WEIGHT) ? idx : '0, value: value};
        script.insert(script.size(), r);
    endtask

    task automatic issue(input t_item it, input bit fixed, input t_result fixed_res);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(DATA_W - IDX_W - VAL_W){1'b0}}, it.operand, it.idx};
        i_s_tuser <= it.op;
        i_s_tlast <= it.last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (train_step(it, res))
            due_results.insert(due_results.size(), fixed ? fixed_res : res);
    endtask

    // Drops valid, lets every expected result arrive, then lets queued work finish.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [RATE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {{(APB_DW - RATE_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == RATE_ADDR)
            rate_reg = value;
        else
            momentum_reg = value;
    endtask

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, kind %0d index %0d value %h", $time,
                         o_m_tuser, o_m_tdata[IDX_W-1:0], o_m_tdata[IDX_W+VAL_W-1:IDX_W]);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (o_m_tuser !== want.kind) begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             want.kind, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[IDX_W-1:0] !== want.idx) begin
                    $display("%0t: result_index expected %0d actual %0d", $time,
                             want.idx, o_m_tdata[IDX_W-1:0]);
                    errors++;
                end
                if (o_m_tdata[IDX_W+VAL_W-1:IDX_W] !== want.value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.value, o_m_tdata[IDX_W+VAL_W-1:IDX_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < N_WEIGHTS; i++) begin
            weight_mem[i] = '0;
            change_mem[i] = '0;
            weight_loaded[i] = 1'b0;
        end
        activation_q = '0;
        grad_sum = 0;
        rate_reg = DEF_RATE;
        momentum_reg = DEF_MOMENTUM;

        // Directed part at the reset register values.
        add_row(OP_LOAD,   0,  32'h0100_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_LOAD,   63, 32'h7FFF_FFFF, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_LOAD,   1,  32'h8000_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_ACC,    0,  32'h0100_0000, 1'b1, 1, KIND_SUM,    32'h0100_0000);
        add_row(OP_ACC,    63, 32'h7FFF_FFFF, 1'b1, 1, KIND_SUM,    32'h7FFF_FFFF);
        add_row(OP_ACC,    1,  32'h7FFF_FFFF, 1'b1, 1, KIND_SUM,    32'h8000_0000);
        add_row(OP_ACC,    0,  32'h8000_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_ACC,    0,  32'h0100_0000, 1'b1, 1, KIND_SUM,    32'h8100_0000);
        add_row(OP_LOAD,   2,  32'h0080_0000, 1'b1, 0, KIND_SUM,    '0);
        add_row(OP_SETACT, 0,  32'h0100_0000, 1'b1, 0, KIND_SUM,    '0);
        add_row(OP_UPDATE, 2,  32'h0100_0000, 1'b0, 0, KIND_WEIGHT, '0);
        add_row(OP_UPDATE, 2,  32'h0100_0000, 1'b0, 0, KIND_WEIGHT, '0);
        // A reload keeps the stored change, so momentum still applies here.
        add_row(OP_LOAD,   2,  32'hFF00_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_UPDATE, 2,  32'hFFFF_FFFF, 1'b0, 0, KIND_WEIGHT, '0);
        add_row(OP_ACC,    2,  32'hFFFF_FFFF, 1'b1, 0, KIND_SUM,    '0);
        add_row(OP_SETACT, 5,  32'h7FFF_FFFF, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_UPDATE, 63, 32'h7FFF_FFFF, 1'b0, 1, KIND_WEIGHT, 32'h7FFF_FFFF);
        add_row(OP_SETACT, 63, 32'h8000_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_UPDATE, 1,  32'h7FFF_FFFF, 1'b0, 1, KIND_WEIGHT, 32'h8000_0000);
        add_row(OP_UPDATE, 0,  32'h0000_0000, 1'b0, 1, KIND_WEIGHT, 32'h0100_0000);
        add_row(OP_UPDATE, 63, 32'h0000_0000, 1'b1, 1, KIND_WEIGHT, 32'h7FFF_FFFF);
        add_row(OP_ACC,    1,  32'h0000_0000, 1'b0, 0, KIND_SUM,    '0);
        add_row(OP_ACC,    63, 32'h0000_0001, 1'b1, 0, KIND_SUM,    '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            issue(script[i].it, script[i].fixed, script[i].res);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(RATE_ADDR, 16'hFFFF);
                    write_reg(MOMENTUM_ADDR, 16'h0000);
                end
                1: begin
                    write_reg(RATE_ADDR, 16'h0000);
                    write_reg(MOMENTUM_ADDR, 16'hFFFF);
                    send_idle_pct = 53;
                    recv_idle_pct = 29;
                end
                2: begin
                    write_reg(RATE_ADDR, 16'($urandom()));
                    write_reg(MOMENTUM_ADDR, 16'($urandom()));
                end
                default: begin
                    write_reg(RATE_ADDR, 16'($urandom_range(16'hFFFF)));
                    write_reg(MOMENTUM_ADDR, 16'hFFFF);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS)
                issue(random_item(), 1'b0, '0);
            settle();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/nwbm_pkg.sv
design/nwbm_front.sv
design/nwbm_back.sv
design/neuron_weight_backprop_momentum.sv
tb/neuron_weight_backprop_momentum_tb.sv
